// ----- sv/ofsp_pkg.sv -----
// ----------------------------------------------------------------------------
// ofsp_pkg
// Shared types and constants of the object-file section parser.
// ----------------------------------------------------------------------------
package ofsp_pkg;

    localparam logic [7:0] MARK_CODE_1 = 8'hCA;
    localparam logic [7:0] MARK_CODE_2 = 8'hDE;
    localparam logic [7:0] MARK_DATA_1 = 8'hDA;
    localparam logic [7:0] MARK_DATA_2 = 8'hDA;
    localparam logic [7:0] MARK_SYM_1  = 8'hC3;
    localparam logic [7:0] MARK_SYM_2  = 8'hB7;

    localparam logic [1:0] KIND_CODE   = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_SYMBOL = 2'd2;

    localparam logic [1:0] REC_CODE_WORD   = 2'd0;
    localparam logic [1:0] REC_DATA_WORD   = 2'd1;
    localparam logic [1:0] REC_LABEL_START = 2'd2;
    localparam logic [1:0] REC_LABEL_BYTE  = 2'd3;

    typedef enum logic [3:0] {
        PH_SCAN     = 4'd0,
        PH_MARK2    = 4'd1,
        PH_ADDR_HI  = 4'd2,
        PH_ADDR_LO  = 4'd3,
        PH_COUNT_HI = 4'd4,
        PH_COUNT_LO = 4'd5,
        PH_WORD_HI  = 4'd6,
        PH_WORD_LO  = 4'd7,
        PH_LABEL    = 4'd8
    } phase_t;

    typedef enum logic [1:0] {
        OP_SET_ADDR    = 2'd0,
        OP_WORD        = 2'd1,
        OP_LABEL_START = 2'd2,
        OP_LABEL_BYTE  = 2'd3
    } op_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       file_end;
    } src_word_t;

    typedef struct packed {
        logic [1:0]  record_kind;
        logic [15:0] target_address;
        logic [15:0] record_value;
        logic        section_last;
    } rec_word_t;

    // front -> back command
    typedef struct packed {
        op_t         op;
        logic [1:0]  kind;
        logic [15:0] value;
        logic        last;
    } cmd_t;

endpackage

// ----- sv/ofsp_front.sv -----
// ----------------------------------------------------------------------------
// ofsp_front
// Byte classifier: tracks section marks, headers and counts, and issues
// address and record commands to the back end.
// ----------------------------------------------------------------------------
module ofsp_front
    import ofsp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      take,
    input  src_word_t word,
    output logic      push,
    output cmd_t      cmd
);

    phase_t      phase_reg, phase_next;
    logic [1:0]  kind_reg, kind_next;
    logic [15:0] count_reg, count_next;
    logic [7:0]  held_reg, held_next;
    logic [15:0] joined;
    logic [7:0]  want;

    assign joined = {held_reg, word.byte_value};

    always_comb
    begin
        unique case (kind_reg)
            KIND_CODE: want = MARK_CODE_2;
            KIND_DATA: want = MARK_DATA_2;
            default:   want = MARK_SYM_2;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SCAN;
            kind_reg  <= KIND_CODE;
            count_reg <= '0;
            held_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            count_reg <= count_next;
            held_reg  <= held_next;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        kind_next  = kind_reg;
        count_next = count_reg;
        held_next  = held_reg;
        push       = 1'b0;
        cmd.op     = OP_SET_ADDR;
        cmd.kind   = kind_reg;
        cmd.value  = joined;
        cmd.last   = 1'b0;
        if (take)
        begin
            unique case (phase_reg)
                PH_MARK2:
                begin
                    phase_next = (word.byte_value == want) ? PH_ADDR_HI : PH_SCAN;
                end
                PH_ADDR_HI, PH_COUNT_HI, PH_WORD_HI:
                begin
                    held_next = word.byte_value;
                    unique case (phase_reg)
                        PH_ADDR_HI:  phase_next = PH_ADDR_LO;
                        PH_COUNT_HI: phase_next = PH_COUNT_LO;
                        default:     phase_next = PH_WORD_LO;
                    endcase
                end
                PH_ADDR_LO:
                begin
                    push       = 1'b1;
                    cmd.op     = OP_SET_ADDR;
                    phase_next = PH_COUNT_HI;
                end
                PH_COUNT_LO:
                begin
                    count_next = joined;
                    if (kind_reg == KIND_SYMBOL)
                    begin
                        push       = 1'b1;
                        cmd.op     = OP_LABEL_START;
                        cmd.value  = '0;
                        cmd.last   = (joined == '0);
                        phase_next = (joined == '0) ? PH_SCAN : PH_LABEL;
                    end
                    else
                    begin
                        phase_next = (joined == '0) ? PH_SCAN : PH_WORD_HI;
                    end
                end
                PH_WORD_LO:
                begin
                    push       = 1'b1;
                    cmd.op     = OP_WORD;
                    cmd.last   = (count_reg == 16'd1);
                    count_next = count_reg - 16'd1;
                    phase_next = (count_reg == 16'd1) ? PH_SCAN : PH_WORD_HI;
                end
                PH_LABEL:
                begin
                    push       = 1'b1;
                    cmd.op     = OP_LABEL_BYTE;
                    cmd.value  = {8'd0, word.byte_value};
                    cmd.last   = (count_reg == 16'd1);
                    count_next = count_reg - 16'd1;
                    phase_next = (count_reg == 16'd1) ? PH_SCAN : PH_LABEL;
                end
                default:
                begin
                    priority if (word.byte_value == MARK_CODE_1)
                    begin
                        kind_next  = KIND_CODE;
                        phase_next = PH_MARK2;
                    end
                    else if (word.byte_value == MARK_DATA_1)
                    begin
                        kind_next  = KIND_DATA;
                        phase_next = PH_MARK2;
                    end
                    else if (word.byte_value == MARK_SYM_1)
                    begin
                        kind_next  = KIND_SYMBOL;
                        phase_next = PH_MARK2;
                    end
                    else
                    begin
                        phase_next = PH_SCAN;
                    end
                end
            endcase
            if (word.file_end)
            begin
                phase_next = PH_SCAN;
            end
        end
    end

endmodule

// ----- sv/ofsp_queue.sv -----
// ----------------------------------------------------------------------------
// ofsp_queue
// Two-entry command queue between front and back end.
// ----------------------------------------------------------------------------
module ofsp_queue
    import ofsp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic empty,
    output cmd_t head
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ----- sv/ofsp_back.sv -----
// ----------------------------------------------------------------------------
// ofsp_back
// Record builder: keeps the running address and drives the output register.
// ----------------------------------------------------------------------------
module ofsp_back
    import ofsp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      empty,
    input  cmd_t      head,
    output logic      pop,
    output logic      rec_valid,
    input  logic      rec_stall,
    output rec_word_t rec_word
);

    logic        valid_reg, valid_next;
    rec_word_t   word_reg, word_next;
    logic [15:0] addr_reg, addr_next;
    logic        load;

    assign load      = !valid_reg || !rec_stall;
    assign pop       = load && !empty;
    assign rec_valid = valid_reg;
    assign rec_word  = word_reg;

    always_comb
    begin
        valid_next = valid_reg;
        word_next  = word_reg;
        addr_next  = addr_reg;
        if (load)
        begin
            valid_next = 1'b0;
            if (!empty)
            begin
                word_next.target_address = addr_reg;
                word_next.record_value   = head.value;
                word_next.section_last   = head.last;
                word_next.record_kind    = REC_LABEL_BYTE;
                unique case (head.op)
                    OP_SET_ADDR:
                    begin
                        addr_next = head.value;
                    end
                    OP_WORD:
                    begin
                        valid_next            = 1'b1;
                        word_next.record_kind = head.kind;
                        addr_next             = addr_reg + 16'd1;
                    end
                    OP_LABEL_START:
                    begin
                        valid_next            = 1'b1;
                        word_next.record_kind = REC_LABEL_START;
                    end
                    OP_LABEL_BYTE:
                    begin
                        valid_next = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            addr_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            addr_reg  <= addr_next;
        end
    end

endmodule

// ----- sv/object_file_section_parser_top.sv -----
// ----------------------------------------------------------------------------
// object_file_section_parser_top
// Object-file byte stream to memory/label records.
//
//   channel | word        | fields
//   --------+-------------+----------------------------------------------
//   src     | src_word_t  | byte_value, file_end
//   rec     | rec_word_t  | record_kind, target_address, record_value,
//           |             | section_last
//
// One byte per cycle unless src stalls; a record passes a queue slot and then
// the output register. The front takes bytes while the two-entry queue has
// room; the back drains one command per cycle, unless a stalled record waits,
// into the address or the output register. Reset returns the parser to
// scanning with address and count cleared. A rec stall with a record waiting
// fills the queue, then stalls src; until then, bytes making no command pass.
// ----------------------------------------------------------------------------
module object_file_section_parser_top
    import ofsp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      src_valid,
    output logic      src_stall,
    input  src_word_t src_word,
    output logic      rec_valid,
    input  logic      rec_stall,
    output rec_word_t rec_word
);

    logic take;
    logic push;
    cmd_t push_cmd;
    logic full;
    logic empty;
    logic pop;
    cmd_t head;

    assign src_stall = full;
    assign take      = src_valid && !full;

    ofsp_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .word  (src_word),
        .push  (push),
        .cmd   (push_cmd)
    );

    ofsp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .empty    (empty),
        .head     (head)
    );

    ofsp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (empty),
        .head      (head),
        .pop       (pop),
        .rec_valid (rec_valid),
        .rec_stall (rec_stall),
        .rec_word  (rec_word)
    );

endmodule

// ----- sv/ofsp_checker.sv -----
// ----------------------------------------------------------------------------
// ofsp_checker
// Port-level checks of the section parser.
// ----------------------------------------------------------------------------
module ofsp_checker
    import ofsp_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      src_valid,
    input logic      src_stall,
    input src_word_t src_word,
    input logic      rec_valid,
    input logic      rec_stall,
    input rec_word_t rec_word
);

    a_rec_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && rec_stall |=> rec_valid && $stable(rec_word))
        else $error("stalled record changed");

    a_src_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        src_stall |-> rec_valid && $past(rec_valid && rec_stall))
        else $error("input stalled without output backpressure");

    a_label_start_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && rec_word.record_kind == REC_LABEL_START
        |-> rec_word.record_value == 16'd0)
        else $error("label start with nonzero value");

    a_label_byte_narrow: assert property (@(posedge clk) disable iff (!rst_n)
        rec_valid && rec_word.record_kind == REC_LABEL_BYTE
        |-> rec_word.record_value[15:8] == 8'd0)
        else $error("label byte wider than 8 bits");

endmodule

bind object_file_section_parser_top ofsp_checker u_ofsp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_word  (src_word),
    .rec_valid (rec_valid),
    .rec_stall (rec_stall),
    .rec_word  (rec_word)
);
